// ===== sv/color_tag_to_ansi_converter_assert.svh =====
`ifndef COLOR_TAG_TO_ANSI_CONVERTER_ASSERT_SVH
`define COLOR_TAG_TO_ANSI_CONVERTER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define CTAC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ctac assertion failed");

// next-cycle implication, disabled in reset
`define CTAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ctac assertion failed");

`endif

// ===== sv/ctac_pkg.sv =====
package ctac_pkg;

    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LC_M   = 8'h6D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_THREE  = 8'h33;
    localparam logic [7:0] CH_FOUR   = 8'h34;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_EIGHT  = 8'h38;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_C   = 8'h63;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_I   = 8'h69;
    localparam logic [7:0] CH_LC_O   = 8'h6F;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_B   = 8'h42;
    localparam logic [7:0] CH_UC_C   = 8'h43;
    localparam logic [7:0] CH_UC_F   = 8'h46;
    localparam logic [7:0] CH_UC_I   = 8'h49;

    localparam logic [1:0] MODE_STRIP = 2'd1;
    localparam logic [1:0] MODE_BG    = 2'd3;

    localparam logic [2:0] COLOR_DIGITS = 3'd6;
    localparam logic [2:0] SKIP_ALPHA   = 3'd2;
    localparam logic [2:0] SKIP_FONT    = 3'd1;

    localparam logic [7:0] DEC_HUND = 8'd100;
    localparam logic [7:0] DEC_TEN  = 8'd10;

    localparam logic [17:0] LUMA_WR    = 18'd299;
    localparam logic [17:0] LUMA_WG    = 18'd587;
    localparam logic [17:0] LUMA_WB    = 18'd114;
    localparam logic [17:0] LUMA_LIMIT = 18'd24000;

    typedef logic [4:0] t_slot;

    // color burst positions
    localparam t_slot S_ESC    = 5'd0;
    localparam t_slot S_BRK    = 5'd1;
    localparam t_slot S_3      = 5'd2;
    localparam t_slot S_8      = 5'd3;
    localparam t_slot S_SEP0   = 5'd4;
    localparam t_slot S_2      = 5'd5;
    localparam t_slot S_SEP1   = 5'd6;
    localparam t_slot S_RH     = 5'd7;
    localparam t_slot S_RT     = 5'd8;
    localparam t_slot S_RO     = 5'd9;
    localparam t_slot S_SEP2   = 5'd10;
    localparam t_slot S_GH     = 5'd11;
    localparam t_slot S_GT     = 5'd12;
    localparam t_slot S_GO     = 5'd13;
    localparam t_slot S_SEP3   = 5'd14;
    localparam t_slot S_BH     = 5'd15;
    localparam t_slot S_BT     = 5'd16;
    localparam t_slot S_BO     = 5'd17;
    localparam t_slot S_FG_M   = 5'd18;
    localparam t_slot S_BG_ESC = 5'd19;
    localparam t_slot S_BG_BRK = 5'd20;
    localparam t_slot S_BG_A   = 5'd21;
    localparam t_slot S_BG_B   = 5'd22;
    localparam t_slot S_BG_C   = 5'd23;
    localparam t_slot S_BG_D   = 5'd24;

    // reset burst positions
    localparam t_slot S_RST_ESC  = 5'd0;
    localparam t_slot S_RST_BRK  = 5'd1;
    localparam t_slot S_RST_CODE = 5'd2;
    localparam t_slot S_RST_LAST = 5'd3;

    typedef enum logic [1:0] {
        PH_TEXT  = 2'd0,
        PH_CARET = 2'd1,
        PH_SKIP  = 2'd2,
        PH_COLOR = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        K_BYTE1 = 2'd0,
        K_BYTE2 = 2'd1,
        K_RESET = 2'd2,
        K_COLOR = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] red;
        logic [7:0] grn;
        logic [7:0] blu;
        logic       bg;
    } t_burst;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    typedef struct packed {
        logic [3:0] hund;
        logic [3:0] tens;
        logic [3:0] ones;
    } t_dec;

    function automatic t_hex hex_decode(input logic [7:0] ch);
        t_hex h;
        h.ok  = 1'b1;
        h.val = ch[3:0];
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            h.val = ch[3:0];
        end else if ((ch >= CH_LC_A && ch <= CH_LC_F) || (ch >= CH_UC_A && ch <= CH_UC_F)) begin
            h.val = ch[3:0] + 4'd9;
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    // reciprocal multiply: v*41>>12 = v/100, v*205>>11 = v/10 for 8-bit v
    function automatic t_dec to_dec(input logic [7:0] v);
        t_dec       d;
        logic [13:0] hp;
        logic [15:0] tp;
        logic [1:0]  h;
        logic [4:0]  tf;
        logic [4:0]  tens_w;
        logic [7:0]  ones_w;
        hp     = {6'd0, v} * 14'd41;
        h      = hp[13:12];
        tp     = {8'd0, v} * 16'd205;
        tf     = tp[15:11];
        tens_w = tf - ({3'd0, h} * 5'd10);
        ones_w = v - ({3'd0, tf} * 8'd10);
        d.hund = {2'd0, h};
        d.tens = tens_w[3:0];
        d.ones = ones_w[3:0];
        return d;
    endfunction

    function automatic logic slot_present(input t_burst d, input t_slot s, input logic white);
        logic p;
        p = 1'b0;
        case (d.kind)
            K_BYTE1: p = (s == S_ESC);
            K_BYTE2: p = (s <= S_BRK);
            K_RESET: p = (s <= S_RST_LAST);
            K_COLOR: begin
                case (s)
                    S_RH:    p = (d.red >= DEC_HUND);
                    S_RT:    p = (d.red >= DEC_TEN);
                    S_GH:    p = (d.grn >= DEC_HUND);
                    S_GT:    p = (d.grn >= DEC_TEN);
                    S_BH:    p = (d.blu >= DEC_HUND);
                    S_BT:    p = (d.blu >= DEC_TEN);
                    default: begin
                        if (s <= S_FG_M) begin
                            p = 1'b1;
                        end else if (s <= S_BG_C) begin
                            p = d.bg;
                        end else if (s == S_BG_D) begin
                            p = d.bg & white;
                        end else begin
                            p = 1'b0;
                        end
                    end
                endcase
            end
            default: p = 1'b0;
        endcase
        return p;
    endfunction

endpackage

// ===== sv/ctac_if.sv =====
interface ctac_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_string;

    modport source (output valid, output char_in, output end_of_string, input ready);
    modport sink   (input valid, input char_in, input end_of_string, output ready);
endinterface

interface ctac_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       last_in_run;

    modport source (output valid, output char_out, output last_in_run, input ready);
    modport sink   (input valid, input char_out, input last_in_run, output ready);
endinterface

// ===== sv/color_tag_to_ansi_converter.sv =====
// channel   | dir | payload                         | transaction on
// i_in      | in  | char_in[7:0], end_of_string     | valid & ready
// o_out     | out | char_out[7:0], last_in_run      | valid & ready
// i_cfg_*   | in  | color_mode[1:0]                 | i_cfg_we
//
// An input byte is parsed in the cycle it is accepted; its output bytes leave a
// burst register one per cycle, while o_out does not stall, into the output register.
// The input is held while a burst is in the burst register, until its last byte
// moves to the output register (up to 25 bytes for a color with background).
// Synchronous active-low reset clears parse state, burst and output; mode is 1.
// A stall on o_out holds the output register and then the burst and the input.

`include "color_tag_to_ansi_converter_assert.svh"

module color_tag_to_ansi_converter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ctac_in_if.sink           i_in,
    ctac_out_if.source        o_out,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_wdata
);

    logic [1:0]        r_mode;
    ctac_pkg::t_phase  r_phase, n_phase;
    logic [2:0]        r_skip, n_skip;
    logic [23:0]       r_color, n_color;
    logic              r_hex_stop, n_hex_stop;
    logic [2:0]        r_digits, n_digits;

    logic              r_desc_valid;
    ctac_pkg::t_burst  r_desc;
    ctac_pkg::t_slot   r_slot;

    logic              r_out_valid;
    logic [7:0]        r_out_char;
    logic              r_out_last;

    ctac_pkg::t_hex    hex;
    logic [23:0]       color_shift;
    logic [2:0]        digits_inc;
    logic [2:0]        skip_dec;
    logic              color_done;
    logic              strip;
    logic              accept;

    ctac_pkg::t_burst  burst;
    logic              burst_ok;

    logic              out_free;
    logic              emit;
    logic              emit_last;
    logic              desc_free;
    logic [17:0]       luma;
    logic              white;
    ctac_pkg::t_dec    dec_r, dec_g, dec_b;
    ctac_pkg::t_slot   slot_p1, slot_p2, slot_p3, slot_next;
    logic              pres1, pres2, pres3;
    logic [7:0]        emit_char;

    assign hex         = ctac_pkg::hex_decode(i_in.char_in);
    assign color_shift = (!r_hex_stop && hex.ok) ? {r_color[19:0], hex.val} : r_color;
    assign digits_inc  = r_digits + 3'd1;
    assign skip_dec    = (r_skip != 3'd0) ? (r_skip - 3'd1) : r_skip;
    assign color_done  = (r_phase == ctac_pkg::PH_COLOR) && (digits_inc >= ctac_pkg::COLOR_DIGITS);
    assign strip       = (r_mode == ctac_pkg::MODE_STRIP);

    assign out_free  = !r_out_valid || o_out.ready;
    assign emit      = r_desc_valid && out_free;
    assign desc_free = !r_desc_valid || (emit && emit_last);
    assign i_in.ready = desc_free && i_rst_n;
    assign accept    = i_in.valid && i_in.ready;

    // parse state
    always_comb begin
        n_phase    = r_phase;
        n_skip     = r_skip;
        n_color    = r_color;
        n_hex_stop = r_hex_stop;
        n_digits   = r_digits;
        case (r_phase)
            ctac_pkg::PH_TEXT: begin
                if (i_in.char_in == ctac_pkg::CH_CARET && !i_in.end_of_string) begin
                    n_phase = ctac_pkg::PH_CARET;
                end
            end
            ctac_pkg::PH_CARET: begin
                n_phase = ctac_pkg::PH_TEXT;
                if (i_in.char_in == ctac_pkg::CH_LC_C) begin
                    n_phase    = ctac_pkg::PH_COLOR;
                    n_color    = 24'd0;
                    n_hex_stop = 1'b0;
                    n_digits   = 3'd0;
                end else if (i_in.char_in == ctac_pkg::CH_LC_A) begin
                    n_phase = ctac_pkg::PH_SKIP;
                    n_skip  = ctac_pkg::SKIP_ALPHA;
                end else if (i_in.char_in == ctac_pkg::CH_LC_F) begin
                    n_phase = ctac_pkg::PH_SKIP;
                    n_skip  = ctac_pkg::SKIP_FONT;
                end
            end
            ctac_pkg::PH_SKIP: begin
                n_skip = skip_dec;
                if (skip_dec == 3'd0) begin
                    n_phase = ctac_pkg::PH_TEXT;
                end
            end
            ctac_pkg::PH_COLOR: begin
                n_color    = color_shift;
                n_hex_stop = r_hex_stop | ~hex.ok;
                n_digits   = digits_inc;
                if (color_done) begin
                    n_phase  = ctac_pkg::PH_TEXT;
                    n_digits = 3'd0;
                end
            end
            default: n_phase = ctac_pkg::PH_TEXT;
        endcase
        if (i_in.end_of_string) begin
            n_phase    = ctac_pkg::PH_TEXT;
            n_skip     = 3'd0;
            n_color    = 24'd0;
            n_hex_stop = 1'b0;
            n_digits   = 3'd0;
        end
    end

    // burst for this byte
    always_comb begin
        burst_ok   = 1'b0;
        burst.kind = ctac_pkg::K_BYTE1;
        burst.b0   = i_in.char_in;
        burst.b1   = i_in.char_in;
        burst.red  = color_shift[23:16];
        burst.grn  = color_shift[15:8];
        burst.blu  = color_shift[7:0];
        burst.bg   = (r_mode == ctac_pkg::MODE_BG);
        case (r_phase)
            ctac_pkg::PH_TEXT: begin
                if (i_in.char_in != ctac_pkg::CH_CARET) begin
                    burst_ok = 1'b1;
                end else if (i_in.end_of_string && strip) begin
                    burst_ok = 1'b1;
                end
            end
            ctac_pkg::PH_CARET: begin
                case (i_in.char_in)
                    ctac_pkg::CH_LC_C, ctac_pkg::CH_LC_A, ctac_pkg::CH_LC_F,
                    ctac_pkg::CH_LC_B, ctac_pkg::CH_LC_I, ctac_pkg::CH_LC_O,
                    ctac_pkg::CH_UC_A, ctac_pkg::CH_UC_F, ctac_pkg::CH_UC_B,
                    ctac_pkg::CH_UC_I: begin
                        burst_ok = 1'b0;
                    end
                    ctac_pkg::CH_LC_R, ctac_pkg::CH_UC_C: begin
                        burst_ok   = !strip;
                        burst.kind = ctac_pkg::K_RESET;
                    end
                    ctac_pkg::CH_CARET: begin
                        burst_ok = 1'b1;
                    end
                    default: begin
                        burst_ok = 1'b1;
                        if (strip) begin
                            burst.kind = ctac_pkg::K_BYTE2;
                            burst.b0   = ctac_pkg::CH_CARET;
                        end
                    end
                endcase
            end
            ctac_pkg::PH_COLOR: begin
                if (color_done && !strip) begin
                    burst_ok   = 1'b1;
                    burst.kind = ctac_pkg::K_COLOR;
                end
            end
            default: burst_ok = 1'b0;
        endcase
    end

    // burst walk
    assign luma  = ({10'd0, r_desc.red} * ctac_pkg::LUMA_WR)
                 + ({10'd0, r_desc.grn} * ctac_pkg::LUMA_WG)
                 + ({10'd0, r_desc.blu} * ctac_pkg::LUMA_WB);
    assign white = (luma < ctac_pkg::LUMA_LIMIT);
    assign dec_r = ctac_pkg::to_dec(r_desc.red);
    assign dec_g = ctac_pkg::to_dec(r_desc.grn);
    assign dec_b = ctac_pkg::to_dec(r_desc.blu);

    assign slot_p1   = r_slot + 5'd1;
    assign slot_p2   = r_slot + 5'd2;
    assign slot_p3   = r_slot + 5'd3;
    assign pres1     = ctac_pkg::slot_present(r_desc, slot_p1, white);
    assign pres2     = ctac_pkg::slot_present(r_desc, slot_p2, white);
    assign pres3     = ctac_pkg::slot_present(r_desc, slot_p3, white);
    assign emit_last = !pres1 && !pres2 && !pres3;
    assign slot_next = pres1 ? slot_p1 : (pres2 ? slot_p2 : slot_p3);

    always_comb begin
        emit_char = r_desc.b0;
        case (r_desc.kind)
            ctac_pkg::K_BYTE1: emit_char = r_desc.b0;
            ctac_pkg::K_BYTE2: emit_char = r_slot[0] ? r_desc.b1 : r_desc.b0;
            ctac_pkg::K_RESET: begin
                case (r_slot)
                    ctac_pkg::S_RST_ESC:  emit_char = ctac_pkg::CH_ESC;
                    ctac_pkg::S_RST_BRK:  emit_char = ctac_pkg::CH_LBRACK;
                    ctac_pkg::S_RST_CODE: emit_char = ctac_pkg::CH_ZERO;
                    default:              emit_char = ctac_pkg::CH_LC_M;
                endcase
            end
            ctac_pkg::K_COLOR: begin
                case (r_slot)
                    ctac_pkg::S_ESC:    emit_char = ctac_pkg::CH_ESC;
                    ctac_pkg::S_BRK:    emit_char = ctac_pkg::CH_LBRACK;
                    ctac_pkg::S_3:      emit_char = ctac_pkg::CH_THREE;
                    ctac_pkg::S_8:      emit_char = ctac_pkg::CH_EIGHT;
                    ctac_pkg::S_SEP0:   emit_char = ctac_pkg::CH_SEMI;
                    ctac_pkg::S_2:      emit_char = ctac_pkg::CH_TWO;
                    ctac_pkg::S_SEP1:   emit_char = ctac_pkg::CH_SEMI;
                    ctac_pkg::S_RH:     emit_char = ctac_pkg::CH_ZERO + {4'd0, dec_r.hund};
                    ctac_pkg::S_RT:     emit_char = ctac_pkg::CH_ZERO + {4'd0, dec_r.tens};
                    ctac_pkg::S_RO:     emit_char = ctac_pkg::CH_ZERO + {4'd0, dec_r.ones};
                    ctac_pkg::S_SEP2:   emit_char = ctac_pkg::CH_SEMI;
                    ctac_pkg::S_GH:     emit_char = ctac_pkg::CH_ZERO + {4'd0, dec_g.hund};
                    ctac_pkg::S_GT:     emit_char = ctac_pkg::CH_ZERO + {4'd0, dec_g.tens};
                    ctac_pkg::S_GO:     emit_char = ctac_pkg::CH_ZERO + {4'd0, dec_g.ones};
                    ctac_pkg::S_SEP3:   emit_char = ctac_pkg::CH_SEMI;
                    ctac_pkg::S_BH:     emit_char = ctac_pkg::CH_ZERO + {4'd0, dec_b.hund};
                    ctac_pkg::S_BT:     emit_char = ctac_pkg::CH_ZERO + {4'd0, dec_b.tens};
                    ctac_pkg::S_BO:     emit_char = ctac_pkg::CH_ZERO + {4'd0, dec_b.ones};
                    ctac_pkg::S_FG_M:   emit_char = ctac_pkg::CH_LC_M;
                    ctac_pkg::S_BG_ESC: emit_char = ctac_pkg::CH_ESC;
                    ctac_pkg::S_BG_BRK: emit_char = ctac_pkg::CH_LBRACK;
                    ctac_pkg::S_BG_A:   emit_char = white ? ctac_pkg::CH_ONE : ctac_pkg::CH_FOUR;
                    ctac_pkg::S_BG_B:   emit_char = ctac_pkg::CH_ZERO;
                    ctac_pkg::S_BG_C:   emit_char = white ? ctac_pkg::CH_SEVEN : ctac_pkg::CH_LC_M;
                    default:            emit_char = ctac_pkg::CH_LC_M;
                endcase
            end
            default: emit_char = r_desc.b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= ctac_pkg::MODE_STRIP;
            r_phase      <= ctac_pkg::PH_TEXT;
            r_skip       <= 3'd0;
            r_color      <= 24'd0;
            r_hex_stop   <= 1'b0;
            r_digits     <= 3'd0;
            r_desc_valid <= 1'b0;
            r_slot       <= ctac_pkg::S_ESC;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (accept) begin
                r_phase    <= n_phase;
                r_skip     <= n_skip;
                r_color    <= n_color;
                r_hex_stop <= n_hex_stop;
                r_digits   <= n_digits;
            end
            if (accept && burst_ok) begin
                r_desc_valid <= 1'b1;
                r_slot       <= ctac_pkg::S_ESC;
            end else if (emit) begin
                if (emit_last) begin
                    r_desc_valid <= 1'b0;
                end else begin
                    r_slot <= slot_next;
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && burst_ok) begin
            r_desc <= burst;
        end
        if (emit) begin
            r_out_char <= emit_char;
            r_out_last <= emit_last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.char_out    = r_out_char;
    assign o_out.last_in_run = r_out_last;

    `CTAC_ASSERT_NEXT(a_burst_hold, i_clk, i_rst_n, r_desc_valid && !emit, r_desc_valid && $stable(r_slot))
    `CTAC_ASSERT_NEXT(a_burst_continue, i_clk, i_rst_n, emit && !emit_last, r_desc_valid)
    `CTAC_ASSERT_NOW(a_skip_count, i_clk, i_rst_n, r_phase == ctac_pkg::PH_SKIP, r_skip != 3'd0)
    `CTAC_ASSERT_NOW(a_digits_idle, i_clk, i_rst_n, r_phase != ctac_pkg::PH_COLOR, r_digits == 3'd0)
    `CTAC_ASSERT_NOW(a_single_slot, i_clk, i_rst_n, r_desc_valid && r_desc.kind == ctac_pkg::K_BYTE1, r_slot == ctac_pkg::S_ESC)

endmodule
